FILE: src/oriented_rectangle_query_macros.svh
// Assertion macros for the oriented rectangle query block.
`ifndef ORIENTED_RECTANGLE_QUERY_MACROS_SVH
`define ORIENTED_RECTANGLE_QUERY_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ORQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, also checked across reset.
`define ORQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/orq_pkg.sv
package orq_pkg;

    localparam int CFG_W  = 31;
    localparam int IN_W   = 208;
    localparam int OUT_W  = 136;

    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_x;
        logic signed [15:0] angle;
        logic signed [31:0] center_y;
        logic signed [31:0] center_x;
    } t_in_item;

    typedef struct packed {
        logic [6:0]         pad;
        logic signed [31:0] near_y;
        logic signed [31:0] near_x;
        logic signed [31:0] proj_max;
        logic signed [31:0] proj_min;
        logic               inside_res;
    } t_out_item;

    localparam logic [CFG_W-1:0]  BOX_RESET   = 31'd65536;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
    localparam int                 MAX_ITER    = 24;

    localparam logic [31:0] ATAN_Q30 [0:MAX_ITER-1] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    function automatic logic signed [31:0] clamp_one(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > ONE_Q30) begin
            r = 32'sd1073741824;
        end else if (v < -ONE_Q30) begin
            r = -32'sd1073741824;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
        logic signed [31:0] r;
        if (v > 51'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -51'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: src/oriented_rectangle_query.sv
// Oriented rectangle query.
// Input stream s_axis: one pose/query per transfer, tdata packs center_x, center_y,
// angle, point_x, point_y, axis_x, axis_y from bit 0 up. Output stream m_axis: one
// result per input, in order; tdata packs inside_res, proj_min, proj_max, near_x,
// near_y from bit 0 up, zero padded to 136 bits.
// Configuration: i_cfg_wen with i_cfg_idx (0 width, 1 height) and i_cfg_wdata;
// write only while no item is in flight.
// Pipeline: one CORDIC stage per iteration, then the multiply/add, compare tree
// and output register stages.
// Throughput: one item per cycle. The whole pipeline advances whenever the output
// register is empty or taken; s_axis_tready follows that advance.
// When the receiver stalls with a result held, the pipeline freezes in place and
// nothing is lost or repeated; input is refused until the result is taken.
// Reset (synchronous, active low) clears all valid bits and sets both box
// dimensions to 1.0.
module oriented_rectangle_query #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wen,
    input  orq_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [orq_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // center_x, center_y, angle, point_x, point_y, axis_x, axis_y
    input  logic [orq_pkg::IN_W-1:0]     s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // inside_res, proj_min, proj_max, near_x, near_y, zero pad
    output logic [orq_pkg::OUT_W-1:0]    m_axis_tdata
);
    import orq_pkg::*;

    localparam int N = TRIG_ITERATIONS;

    logic [CFG_W-1:0] r_box_width, r_box_height;
    logic             en;
    t_in_item         in_item;
    t_out_item        r_out;
    logic             r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_width  <= BOX_RESET;
            r_box_height <= BOX_RESET;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:  r_box_width  <= i_cfg_wdata;
                CFG_HEIGHT: r_box_height <= i_cfg_wdata;
            endcase
        end
    end

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign in_item       = t_in_item'(s_axis_tdata);

    // ---------------- input stage and CORDIC ----------------
    logic                r_v    [0:N];
    logic signed [33:0]  r_x    [0:N];
    logic signed [33:0]  r_y    [0:N];
    logic signed [34:0]  r_z    [0:N];
    logic                r_neg  [0:N];
    logic signed [31:0]  r_cx   [0:N];
    logic signed [31:0]  r_cy   [0:N];
    logic signed [31:0]  r_px   [0:N];
    logic signed [31:0]  r_py   [0:N];
    logic signed [31:0]  r_ax   [0:N];
    logic signed [31:0]  r_ay   [0:N];

    logic signed [34:0]  z_raw, n_z;
    logic                n_neg;

    always_comb begin
        z_raw = 35'(in_item.angle) <<< 17;
        n_z   = z_raw;
        n_neg = 1'b0;
        if (z_raw > HALF_PI_Q30) begin
            n_z   = z_raw - PI_Q30;
            n_neg = 1'b1;
        end else if (z_raw < -HALF_PI_Q30) begin
            n_z   = z_raw + PI_Q30;
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x[0]   <= GAIN_Q30;
            r_y[0]   <= '0;
            r_z[0]   <= n_z;
            r_neg[0] <= n_neg;
            r_cx[0]  <= in_item.center_x;
            r_cy[0]  <= in_item.center_y;
            r_px[0]  <= in_item.point_x;
            r_py[0]  <= in_item.point_y;
            r_ax[0]  <= in_item.axis_x;
            r_ay[0]  <= in_item.axis_y;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_cordic
        localparam logic signed [34:0] ATAN_I = $signed(35'(ATAN_Q30[i]));
        logic signed [33:0] xs, ys;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - ATAN_I;
                end else begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + ATAN_I;
                end
                r_neg[i+1] <= r_neg[i];
                r_cx[i+1]  <= r_cx[i];
                r_cy[i+1]  <= r_cy[i];
                r_px[i+1]  <= r_px[i];
                r_py[i+1]  <= r_py[i];
                r_ax[i+1]  <= r_ax[i];
                r_ay[i+1]  <= r_ay[i];
            end
        end
    end

    // ---------------- clamp, sign, point offset ----------------
    logic               r_t_v;
    logic signed [31:0] r_t_c, r_t_s, r_t_cx, r_t_cy, r_t_px, r_t_py, r_t_ax, r_t_ay;
    logic signed [32:0] r_t_lx, r_t_ly;
    logic signed [31:0] c_cl, s_cl;

    assign c_cl = clamp_one(r_x[N]);
    assign s_cl = clamp_one(r_y[N]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_v <= 1'b0;
        end else if (en) begin
            r_t_v <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t_c  <= r_neg[N] ? -c_cl : c_cl;
            r_t_s  <= r_neg[N] ? -s_cl : s_cl;
            r_t_cx <= r_cx[N];
            r_t_cy <= r_cy[N];
            r_t_px <= r_px[N];
            r_t_py <= r_py[N];
            r_t_ax <= r_ax[N];
            r_t_ay <= r_ay[N];
            r_t_lx <= 33'(r_px[N]) - 33'(r_cx[N]);
            r_t_ly <= 33'(r_py[N]) - 33'(r_cy[N]);
        end
    end

    // ---------------- first products ----------------
    logic               r_m_v;
    logic signed [63:0] r_m_cw, r_m_sh, r_m_sw, r_m_ch;
    logic signed [64:0] r_m_lxc, r_m_lys, r_m_lyc, r_m_lxs;
    logic signed [31:0] r_m_cx, r_m_cy, r_m_px, r_m_py, r_m_ax, r_m_ay;
    logic signed [31:0] w_s, h_s;

    assign w_s = $signed({1'b0, r_box_width});
    assign h_s = $signed({1'b0, r_box_height});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (en) begin
            r_m_v <= r_t_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_cw  <= 64'(r_t_c) * 64'(w_s);
            r_m_sh  <= 64'(r_t_s) * 64'(h_s);
            r_m_sw  <= 64'(r_t_s) * 64'(w_s);
            r_m_ch  <= 64'(r_t_c) * 64'(h_s);
            r_m_lxc <= 65'(r_t_lx) * 65'(r_t_c);
            r_m_lys <= 65'(r_t_ly) * 65'(r_t_s);
            r_m_lyc <= 65'(r_t_ly) * 65'(r_t_c);
            r_m_lxs <= 65'(r_t_lx) * 65'(r_t_s);
            r_m_cx  <= r_t_cx;
            r_m_cy  <= r_t_cy;
            r_m_px  <= r_t_px;
            r_m_py  <= r_t_py;
            r_m_ax  <= r_t_ax;
            r_m_ay  <= r_t_ay;
        end
    end

    // ---------------- corners and inverse rotation ----------------
    logic               r_a_v;
    logic signed [33:0] r_a_vx [0:3];
    logic signed [33:0] r_a_vy [0:3];
    logic signed [65:0] r_a_rx, r_a_ry;
    logic signed [31:0] r_a_px, r_a_py, r_a_ax, r_a_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en) begin
            r_a_v <= r_m_v;
        end
    end

    // corner order: (-w,-h), (+w,-h), (+w,+h), (-w,+h)
    for (genvar k = 0; k < 4; k++) begin : g_corner
        localparam bit SX = (k == 1) || (k == 2);
        localparam bit SY = (k >= 2);
        logic signed [65:0] cw, sh, sw, ch, tx, ty;
        assign cw = SX ? 66'(r_m_cw) : -66'(r_m_cw);
        assign sw = SX ? 66'(r_m_sw) : -66'(r_m_sw);
        assign sh = SY ? 66'(r_m_sh) : -66'(r_m_sh);
        assign ch = SY ? 66'(r_m_ch) : -66'(r_m_ch);
        assign tx = cw - sh + 66'sd1073741824;
        assign ty = sw + ch + 66'sd1073741824;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_a_vx[k] <= 34'(r_m_cx) + 34'(tx >>> 31);
                r_a_vy[k] <= 34'(r_m_cy) + 34'(ty >>> 31);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_rx <= 66'(r_m_lxc) + 66'(r_m_lys);
            r_a_ry <= 66'(r_m_lyc) - 66'(r_m_lxs);
            r_a_px <= r_m_px;
            r_a_py <= r_m_py;
            r_a_ax <= r_m_ax;
            r_a_ay <= r_m_ay;
        end
    end

    // ---------------- projection and distance products ----------------
    logic               r_q_v, r_q_in;
    logic signed [65:0] r_q_pa  [0:3];
    logic signed [65:0] r_q_pb  [0:3];
    logic signed [69:0] r_q_dxx [0:3];
    logic signed [69:0] r_q_dyy [0:3];
    logic signed [33:0] r_q_vx  [0:3];
    logic signed [33:0] r_q_vy  [0:3];
    logic signed [65:0] wl, hl;

    assign wl = $signed(66'({r_box_width, 29'b0}));
    assign hl = $signed(66'({r_box_height, 29'b0}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_v <= 1'b0;
        end else if (en) begin
            r_q_v <= r_a_v;
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_prod
        logic signed [34:0] dx, dy;
        assign dx = 35'(r_a_vx[k]) - 35'(r_a_px);
        assign dy = 35'(r_a_vy[k]) - 35'(r_a_py);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_q_pa[k]  <= 66'(r_a_vx[k]) * 66'(r_a_ax);
                r_q_pb[k]  <= 66'(r_a_vy[k]) * 66'(r_a_ay);
                r_q_dxx[k] <= 70'(dx) * 70'(dx);
                r_q_dyy[k] <= 70'(dy) * 70'(dy);
                r_q_vx[k]  <= r_a_vx[k];
                r_q_vy[k]  <= r_a_vy[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q_in <= (r_a_rx >= -wl) && (r_a_rx <= wl) && (r_a_ry >= -hl) && (r_a_ry <= hl);
        end
    end

    // ---------------- sums ----------------
    logic               r_s_v, r_s_in;
    logic signed [50:0] r_s_p  [0:3];
    logic [70:0]        r_s_d  [0:3];
    logic signed [33:0] r_s_vx [0:3];
    logic signed [33:0] r_s_vy [0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else if (en) begin
            r_s_v <= r_q_v;
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_sum
        logic signed [66:0] psum;
        assign psum = 67'(r_q_pa[k]) + 67'(r_q_pb[k]);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s_p[k]  <= 51'(psum >>> 16);
                r_s_d[k]  <= 71'(unsigned'(r_q_dxx[k])) + 71'(unsigned'(r_q_dyy[k]));
                r_s_vx[k] <= r_q_vx[k];
                r_s_vy[k] <= r_q_vy[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_in <= r_q_in;
        end
    end

    // ---------------- pairwise reduce ----------------
    logic               r_r_v, r_r_in;
    logic signed [50:0] r_r_min [0:1];
    logic signed [50:0] r_r_max [0:1];
    logic [70:0]        r_r_d   [0:1];
    logic signed [33:0] r_r_nx  [0:1];
    logic signed [33:0] r_r_ny  [0:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_v <= 1'b0;
        end else if (en) begin
            r_r_v <= r_s_v;
        end
    end

    for (genvar j = 0; j < 2; j++) begin : g_pair
        localparam int A = 2 * j;
        localparam int B = 2 * j + 1;
        logic take_b;
        assign take_b = r_s_d[B] < r_s_d[A];

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_r_min[j] <= (r_s_p[B] < r_s_p[A]) ? r_s_p[B] : r_s_p[A];
                r_r_max[j] <= (r_s_p[B] > r_s_p[A]) ? r_s_p[B] : r_s_p[A];
                r_r_d[j]   <= take_b ? r_s_d[B]  : r_s_d[A];
                r_r_nx[j]  <= take_b ? r_s_vx[B] : r_s_vx[A];
                r_r_ny[j]  <= take_b ? r_s_vy[B] : r_s_vy[A];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r_in <= r_s_in;
        end
    end

    // ---------------- final reduce, saturate, output register ----------------
    t_out_item          n_out;
    logic               take_hi;
    logic signed [50:0] pmin, pmax;
    logic signed [33:0] nx, ny;

    always_comb begin
        take_hi = r_r_d[1] < r_r_d[0];
        pmin    = (r_r_min[1] < r_r_min[0]) ? r_r_min[1] : r_r_min[0];
        pmax    = (r_r_max[1] > r_r_max[0]) ? r_r_max[1] : r_r_max[0];
        nx      = take_hi ? r_r_nx[1] : r_r_nx[0];
        ny      = take_hi ? r_r_ny[1] : r_r_ny[0];
        n_out            = '0;
        n_out.inside_res = r_r_in;
        n_out.proj_min   = sat32(pmin);
        n_out.proj_max   = sat32(pmax);
        n_out.near_x     = sat32(51'(nx));
        n_out.near_y     = sat32(51'(ny));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out);

endmodule

FILE: src/orq_checker.sv
`include "oriented_rectangle_query_macros.svh"

module orq_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [orq_pkg::OUT_W-1:0] m_axis_tdata
);
    import orq_pkg::*;

    `ORQ_ASSERT_NEXT(a_out_hold, i_rst_n && m_axis_tvalid && !m_axis_tready, !i_rst_n || (m_axis_tvalid && $stable(m_axis_tdata)), "stalled output changed")
    `ORQ_ASSERT_NEXT(a_reset_clear, !i_rst_n, !m_axis_tvalid, "output valid after reset")
    `ORQ_ASSERT_SAME(a_ready_follows, m_axis_tready, s_axis_tready, "input refused while output taken")
    `ORQ_ASSERT_SAME(a_stall_cause, !s_axis_tready, m_axis_tvalid, "input refused without held result")

endmodule

bind oriented_rectangle_query orq_checker u_orq_checker (.*);

FILE: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import orq_pkg::*;

    typedef logic signed [127:0] t_wide;

    class rect_scoreboard;
        t_out_item want_q[$];
        logic [CFG_W-1:0] box_w;
        logic [CFG_W-1:0] box_h;
        int errors;
        int checked;

        function new();
            box_w = BOX_RESET;
            box_h = BOX_RESET;
            errors = 0;
            checked = 0;
        endfunction

        function automatic logic signed [31:0] clip32(t_wide v);
            if (v > t_wide'(64'sd2147483647)) return 32'sh7FFFFFFF;
            if (v < -t_wide'(64'sd2147483648)) return 32'sh80000000;
            return v[31:0];
        endfunction

        // CORDIC sine/cosine in Q.30 with single pi fold
        function automatic void sincos(logic signed [15:0] ang, output longint c,
                                       output longint s);
            longint z, x, y, xs, ys;
            bit neg;
            z = longint'(ang) * 131072;
            x = GAIN_Q30;
            y = 0;
            neg = 0;
            if (z > HALF_PI_Q30) begin
                z -= PI_Q30;
                neg = 1;
            end else if (z < -HALF_PI_Q30) begin
                z += PI_Q30;
                neg = 1;
            end
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x -= ys;
                    y += xs;
                    z -= longint'(ATAN_Q30[i]);
                end else begin
                    x += ys;
                    y -= xs;
                    z += longint'(ATAN_Q30[i]);
                end
            end
            if (x > ONE_Q30) x = ONE_Q30;
            if (x < -ONE_Q30) x = -ONE_Q30;
            if (y > ONE_Q30) y = ONE_Q30;
            if (y < -ONE_Q30) y = -ONE_Q30;
            c = neg ? -x : x;
            s = neg ? -y : y;
        endfunction

        function void note_query(t_in_item q);
            longint cl, sl;
            t_wide c, s, cx, cy, px, py, ax, ay, w, h, ox, oy, vx, vy, p, d, best;
            t_wide pmin, pmax, nx, ny, lx, ly, rx, ry, wl, hl;
            t_out_item r;
            sincos(q.angle, cl, sl);
            c = cl;
            s = sl;
            cx = q.center_x;
            cy = q.center_y;
            px = q.point_x;
            py = q.point_y;
            ax = q.axis_x;
            ay = q.axis_y;
            w = {97'd0, box_w};
            h = {97'd0, box_h};
            for (int k = 0; k < 4; k++) begin
                ox = (k == 0 || k == 3) ? -w : w;
                oy = (k < 2) ? -h : h;
                vx = cx + ((c * ox - s * oy + (t_wide'(1) <<< 30)) >>> 31);
                vy = cy + ((s * ox + c * oy + (t_wide'(1) <<< 30)) >>> 31);
                p = (vx * ax + vy * ay) >>> 16;
                d = (vx - px) * (vx - px) + (vy - py) * (vy - py);
                if (k == 0 || d < best) begin
                    best = d;
                    nx = vx;
                    ny = vy;
                end
                if (k == 0 || p < pmin) pmin = p;
                if (k == 0 || p > pmax) pmax = p;
            end
            lx = px - cx;
            ly = py - cy;
            rx = lx * c + ly * s;
            ry = ly * c - lx * s;
            wl = w <<< 29;
            hl = h <<< 29;
            r = '0;
            r.inside_res = (rx >= -wl && rx <= wl && ry >= -hl && ry <= hl);
            r.proj_min = clip32(pmin);
            r.proj_max = clip32(pmax);
            r.near_x = clip32(nx);
            r.near_y = clip32(ny);
            want_q = {want_q, r};
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch %s: got %h want %h (result %0d)", what, got, want, checked);
        endtask

        task check_result(t_out_item got);
            t_out_item w;
            if (want_q.size() == 0) begin
                report("unexpected transfer", got.proj_min, 0);
                return;
            end
            w = want_q.pop_front();
            if (got.inside_res !== w.inside_res)
                report("inside", 32'(got.inside_res), 32'(w.inside_res));
            if (got.proj_min !== w.proj_min) report("proj_min", got.proj_min, w.proj_min);
            if (got.proj_max !== w.proj_max) report("proj_max", got.proj_max, w.proj_max);
            if (got.near_x !== w.near_x) report("near_x", got.near_x, w.near_x);
            if (got.near_y !== w.near_y) report("near_y", got.near_y, w.near_y);
            if (got.pad !== 7'd0) report("pad", 32'(got.pad), 0);
            checked++;
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wen;
    t_cfg_idx i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_wdata;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;

    rect_scoreboard sb;
    int stall_pct;
    int gap_pct;
    int hold_left;
    int sent;
    int settings;

    oriented_rectangle_query dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wen(i_cfg_wen),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // receiver: random stalls plus commanded long hold-off
    initial begin
        m_axis_tready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(t_out_item'(m_axis_tdata));
    end

    task send_query(t_in_item q);
        @(negedge i_clk);
        s_axis_tvalid <= 1;
        s_axis_tdata <= q;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_query(q);
        sent++;
    endtask

    task pause(int n);
        @(negedge i_clk);
        s_axis_tvalid <= 0;
        repeat (n) @(negedge i_clk);
    endtask

    task drain();
        pause(0);
        while (sb.want_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task write_box(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        @(negedge i_clk);
        i_cfg_wen <= 1;
        i_cfg_idx <= CFG_WIDTH;
        i_cfg_wdata <= w;
        @(negedge i_clk);
        i_cfg_idx <= CFG_HEIGHT;
        i_cfg_wdata <= h;
        @(negedge i_clk);
        i_cfg_wen <= 0;
        sb.box_w = w;
        sb.box_h = h;
        settings++;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFFFFFF;
                    1: return 32'h80000000;
                    2: return 32'h0;
                    default: return 32'hFFFFFFFF;
                endcase
            end
            default: return 32'($signed($urandom_range(0, 2 ** 27)) - 2 ** 26);
        endcase
    endfunction

    function automatic t_in_item rand_query();
        t_in_item q;
        longint lim;
        q.center_x = rand_coord();
        q.center_y = rand_coord();
        q.angle = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                               : 16'($signed($urandom_range(0, 51472)) - 25736);
        q.axis_x = rand_coord();
        q.axis_y = rand_coord();
        if ($urandom_range(0, 1)) begin
            // point near the rectangle so inside/outside both occur
            lim = longint'(sb.box_w) + longint'(sb.box_h) + 4;
            if (lim > 2 ** 30) lim = 2 ** 30;
            q.point_x = q.center_x + 32'($urandom_range(0, 32'(2 * lim)) - lim);
            q.point_y = q.center_y + 32'($urandom_range(0, 32'(2 * lim)) - lim);
        end else begin
            q.point_x = rand_coord();
            q.point_y = rand_coord();
        end
        return q;
    endfunction

    task random_queries(int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 20);
            repeat (burst) begin
                if (n > 0) send_query(rand_query());
                n--;
            end
            if ($urandom_range(0, 99) < gap_pct) pause($urandom_range(1, 6));
        end
    endtask

    task directed_queries();
        t_in_item q;
        logic signed [15:0] angs [8] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868,
                                          -16'sd12868, 16'sh7FFF, 16'sh8000, 16'sd6434};
        for (int i = 0; i < 8; i++) begin
            q = '0;
            q.angle = angs[i];
            q.axis_x = 32'sh00010000;
            q.axis_y = i[0] ? 32'sh7FFFFFFF : 32'sh80000000;
            q.point_x = (i < 4) ? 32'sd0 : 32'sh00008000;
            q.point_y = (i < 4) ? 32'sd0 : -32'sh00008000;
            send_query(q);
        end
        q = '0;
        q.center_x = 32'sh7FFFFFFF;
        q.center_y = 32'sh7FFFFFFF;
        q.point_x = 32'sh80000000;
        q.point_y = 32'sh80000000;
        q.axis_x = 32'sh7FFFFFFF;
        q.axis_y = 32'sh7FFFFFFF;
        send_query(q);
        q.center_x = 32'sh80000000;
        q.center_y = 32'sh80000000;
        q.point_x = 32'sh7FFFFFFF;
        q.axis_x = 32'sh80000000;
        q.axis_y = 32'sh80000000;
        q.angle = 16'sd25736;
        send_query(q);
        // point exactly on a corner and just past an edge of the reset-size box
        q = '0;
        q.point_x = 32'sh00008000;
        q.point_y = 32'sh00008000;
        send_query(q);
        q.point_y = 32'sd0;
        q.point_x = 32'sh00008001;
        send_query(q);
        q.point_x = 32'hFFFFFFFF;
        q.angle = -16'sd1;
        q.axis_x = 32'hFFFFFFFF;
        send_query(q);
    endtask

    initial begin
        sb = new();
        i_rst_n = 0;
        i_cfg_wen = 0;
        i_cfg_idx = CFG_WIDTH;
        i_cfg_wdata = '0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        stall_pct = 0;
        gap_pct = 0;
        hold_left = 0;
        sent = 0;
        settings = 1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        directed_queries();
        random_queries(130);
        drain();

        write_box('0, '0);
        directed_queries();
        stall_pct = 30;
        gap_pct = 50;
        random_queries(130);
        drain();

        write_box(31'h7FFFFFFF, 31'h7FFFFFFF);
        directed_queries();
        random_queries(130);
        drain();

        write_box(31'd196608, 31'd32768);
        stall_pct = 0;
        gap_pct = 0;
        hold_left = 400;
        random_queries(150);
        drain();

        for (int p = 0; p < 3; p++) begin
            write_box($urandom_range(0, 2 ** 19), $urandom);
            stall_pct = $urandom_range(0, 60);
            gap_pct = $urandom_range(0, 80);
            random_queries(120);
            drain();
        end

        $display("covered %0d queries over %0d box sizes, including zero, full-range and",
                 sent, settings);
        $display("saturating poses, out-of-range angles and a long output stall");
        if (sb.errors == 0 && sb.want_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+src
src/orq_pkg.sv
src/oriented_rectangle_query.sv
src/orq_checker.sv
dv/tb.sv
